// ===== hw/rtl/ebc_pkg.sv =====
// Shared types and constants of the biquad cascade equalizer.
package ebc_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef logic [3:0] step_t;

    // Sequencer steps within one band.
    localparam step_t STEP_RD0  = 4'd0;  // read c0 and d0
    localparam step_t STEP_RD1  = 4'd1;  // read c1 and d1, multiply c0*d0
    localparam step_t STEP_MUL1 = 4'd2;  // multiply c1*d1
    localparam step_t STEP_ACCW = 4'd3;  // finish feedback sum
    localparam step_t STEP_W    = 4'd4;  // form w, store d1, read c2
    localparam step_t STEP_M2   = 4'd5;  // multiply c2*w, store d0, read c3
    localparam step_t STEP_M3   = 4'd6;  // multiply c3*d0, read c4
    localparam step_t STEP_M4   = 4'd7;  // multiply c4*d1
    localparam step_t STEP_ACCY = 4'd8;  // finish feedforward sum
    localparam step_t STEP_Y    = 4'd9;  // form y

    localparam int NUM_COEFS = 5;
    localparam int QSHIFT    = 28;

    localparam logic [2:0] COEF_C0 = 3'd0;
    localparam logic [2:0] COEF_C1 = 3'd1;
    localparam logic [2:0] COEF_C2 = 3'd2;
    localparam logic [2:0] COEF_C3 = 3'd3;
    localparam logic [2:0] COEF_C4 = 3'd4;

    localparam logic [0:0] MODE_SAMPLE = 1'b0;
    localparam logic [0:0] MODE_COEF   = 1'b1;

    localparam logic [31:0] Q_ONE   = 32'h1000_0000;
    localparam logic [31:0] W_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN   = 32'h8000_0000;
    localparam logic [23:0] Y_MAX   = 24'h7F_FFFF;
    localparam logic [23:0] Y_MIN   = 24'h80_0000;
    localparam logic signed [65:0] ROUND_HALF = 66'sd134217728;

endpackage

// ===== hw/rtl/eq_biquad_cascade_unit.sv =====
// Top level of the multichannel cascaded direct-form-II biquad equalizer.
//
// Each channel's sample runs through BANDS biquads computed on one shared
// 32x32 multiplier and accumulator under a ten-step sequencer. In each band
// it reads the first coefficient and delay word from registered memory,
// forms the five products on the single multiplier, registers each product
// ahead of its sum, and forms the two rounded sums. A finishing state then
// hands the result to the output register once that register is free, and
// returns to idle. A coefficient write goes into its RAM as it is accepted.
// Delay words and coefficients live in two RAMs; after reset a clearing pass
// over every coefficient address loads zero delay words and passthrough
// coefficients, and no item is accepted until it is done. The result sits in
// an output register, so coefficient writes are taken while it waits.
module eq_biquad_cascade_unit #(
    parameter int CHANNELS = 8,
    parameter int BANDS    = 6
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [2:0]  s_channel,
    input  logic [2:0]  s_band,
    input  logic [2:0]  s_coef_index,
    input  logic [31:0] s_coef_value,
    input  logic [23:0] s_sample,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_channel,
    output logic [23:0] m_out_sample,
    output logic        m_clipped
);
    import ebc_pkg::*;

    localparam int CDEPTH = CHANNELS * BANDS * NUM_COEFS;
    localparam int DDEPTH = CHANNELS * BANDS * 2;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int BW     = (BANDS > 1) ? $clog2(BANDS) : 1;

    state_t state_reg, state_next;
    step_t  step_reg;
    logic [BW-1:0]  band_reg;
    logic [CAW-1:0] cbase_reg;
    logic [DAW-1:0] dbase_reg;
    logic [CAW-1:0] clr_cnt_reg;
    logic [2:0]     clr_slot_reg;
    logic [2:0]     ch_reg;
    logic [23:0]    x_reg;
    logic [31:0]    w_reg;
    logic [31:0]    d0_reg;
    logic [31:0]    d1_reg;
    logic           clip_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic           m_valid_reg;
    logic [2:0]     out_ch_reg;
    logic [23:0]    out_sample_reg;
    logic           out_clip_reg;

    logic           accept;
    logic           ch_ok;
    logic           wr_ok;
    logic           last_band;
    logic           out_free;

    logic           coef_we;
    logic [CAW-1:0] coef_waddr;
    logic [31:0]    coef_wdata;
    logic [CAW-1:0] coef_raddr;
    logic [31:0]    coef_q;
    logic           dly_we;
    logic [DAW-1:0] dly_waddr;
    logic [31:0]    dly_wdata;
    logic [DAW-1:0] dly_raddr;
    logic [31:0]    dly_q;
    logic [31:0]    op_b;

    logic signed [65:0] acc_rnd;
    logic [37:0]    rnd;
    logic [38:0]    w_sum;
    logic           w_ovf;
    logic [31:0]    w_sat;
    logic           y_ovf;
    logic [23:0]    y_sat;

    assign accept    = s_valid && s_ready;
    assign ch_ok     = 32'(s_channel) < CHANNELS;
    assign wr_ok     = (32'(s_band) < BANDS) && (32'(s_coef_index) < NUM_COEFS);
    assign last_band = band_reg == BW'(BANDS - 1);
    assign out_free  = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CAW'(CDEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && ch_ok && s_mode == MODE_SAMPLE) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_reg == STEP_Y && last_band) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Sequencer outputs: memory ports and multiplier operand.
    always_comb begin
        s_ready    = 1'b0;
        coef_we    = 1'b0;
        coef_waddr = CAW'((32'(s_channel) * BANDS + 32'(s_band)) * NUM_COEFS
                          + 32'(s_coef_index));
        coef_wdata = s_coef_value;
        coef_raddr = cbase_reg;
        dly_we     = 1'b0;
        dly_waddr  = dbase_reg;
        dly_wdata  = w_reg;
        dly_raddr  = dbase_reg;
        op_b       = dly_q;
        unique case (state_reg)
            ST_CLEAR: begin
                coef_we    = 1'b1;
                coef_waddr = clr_cnt_reg;
                coef_wdata = (clr_slot_reg == COEF_C2) ? Q_ONE : 32'd0;
                dly_we     = 32'(clr_cnt_reg) < DDEPTH;
                dly_waddr  = clr_cnt_reg[DAW-1:0];
                dly_wdata  = 32'd0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                coef_we = accept && ch_ok && s_mode == MODE_COEF && wr_ok;
            end
            ST_RUN: begin
                case (step_reg)
                    STEP_RD0: begin
                        coef_raddr = cbase_reg + CAW'(COEF_C0);
                        dly_raddr  = dbase_reg;
                    end
                    STEP_RD1: begin
                        coef_raddr = cbase_reg + CAW'(COEF_C1);
                        dly_raddr  = dbase_reg + DAW'(1);
                    end
                    STEP_W: begin
                        coef_raddr = cbase_reg + CAW'(COEF_C2);
                        dly_we     = 1'b1;
                        dly_waddr  = dbase_reg + DAW'(1);
                        dly_wdata  = d0_reg;
                    end
                    STEP_M2: begin
                        coef_raddr = cbase_reg + CAW'(COEF_C3);
                        op_b       = w_reg;
                        dly_we     = 1'b1;
                        dly_waddr  = dbase_reg;
                        dly_wdata  = w_reg;
                    end
                    STEP_M3: begin
                        coef_raddr = cbase_reg + CAW'(COEF_C4);
                        op_b       = d0_reg;
                    end
                    STEP_M4: begin
                        op_b = d1_reg;
                    end
                    default: begin
                        op_b = dly_q;
                    end
                endcase
            end
            ST_FINISH: begin
                s_ready = 1'b0;
            end
            default: s_ready = 1'b0;
        endcase
    end

    // Rounding and saturation of the accumulated Q37.28 sum.
    always_comb begin
        acc_rnd = acc_reg + ROUND_HALF;
        rnd     = acc_rnd[65:28];
        w_sum   = {rnd[37], rnd} + {{15{x_reg[23]}}, x_reg};
        w_ovf   = w_sum[38:31] != {8{w_sum[38]}};
        w_sat   = w_ovf ? (w_sum[38] ? W_MIN : W_MAX) : w_sum[31:0];
        y_ovf   = rnd[37:23] != {15{rnd[37]}};
        y_sat   = y_ovf ? (rnd[37] ? Y_MIN : Y_MAX) : rnd[23:0];
    end

    ebc_ram #(
        .WIDTH (32),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .aclk    (aclk),
        .we      (coef_we),
        .wr_addr (coef_waddr),
        .wr_data (coef_wdata),
        .rd_addr (coef_raddr),
        .rd_data (coef_q)
    );

    ebc_ram #(
        .WIDTH (32),
        .DEPTH (DDEPTH)
    ) u_delay_ram (
        .aclk    (aclk),
        .we      (dly_we),
        .wr_addr (dly_waddr),
        .wr_data (dly_wdata),
        .rd_addr (dly_raddr),
        .rd_data (dly_q)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            step_reg     <= STEP_RD0;
            band_reg     <= '0;
            clr_cnt_reg  <= '0;
            clr_slot_reg <= COEF_C0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg  <= clr_cnt_reg + CAW'(1);
                clr_slot_reg <= (clr_slot_reg == COEF_C4) ? COEF_C0 : clr_slot_reg + 3'd1;
            end
            if (state_reg == ST_IDLE) begin
                step_reg <= STEP_RD0;
                band_reg <= '0;
            end else if (state_reg == ST_RUN) begin
                if (step_reg == STEP_Y) begin
                    step_reg <= STEP_RD0;
                    band_reg <= band_reg + BW'(1);
                end else begin
                    step_reg <= step_reg + 4'd1;
                end
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= $signed(coef_q) * $signed(op_b);
        if (state_reg == ST_IDLE) begin
            ch_reg    <= s_channel;
            x_reg     <= s_sample;
            clip_reg  <= 1'b0;
            cbase_reg <= CAW'(32'(s_channel) * BANDS * NUM_COEFS);
            dbase_reg <= DAW'(32'(s_channel) * BANDS * 2);
        end else if (state_reg == ST_RUN) begin
            case (step_reg)
                STEP_RD1:  d0_reg  <= dly_q;
                STEP_MUL1: begin
                    d1_reg  <= dly_q;
                    acc_reg <= 66'(prod_reg);
                end
                STEP_ACCW: acc_reg <= acc_reg + 66'(prod_reg);
                STEP_W: begin
                    w_reg    <= w_sat;
                    clip_reg <= clip_reg | w_ovf;
                end
                STEP_M3:   acc_reg <= 66'(prod_reg);
                STEP_M4:   acc_reg <= acc_reg + 66'(prod_reg);
                STEP_ACCY: acc_reg <= acc_reg + 66'(prod_reg);
                STEP_Y: begin
                    x_reg     <= y_sat;
                    clip_reg  <= clip_reg | y_ovf;
                    cbase_reg <= cbase_reg + CAW'(NUM_COEFS);
                    dbase_reg <= dbase_reg + DAW'(2);
                end
                default: acc_reg <= acc_reg;
            endcase
        end
        if (state_reg == ST_FINISH && out_free) begin
            out_ch_reg     <= ch_reg;
            out_sample_reg <= x_reg;
            out_clip_reg   <= clip_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = out_ch_reg;
    assign m_out_sample  = out_sample_reg;
    assign m_clipped     = out_clip_reg;

    // A result appears only out of the finishing state.
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the finishing state");

    // The band counter never runs past the last band while filtering.
    a_band_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> 32'(band_reg) < BANDS)
        else $error("band counter out of range");

    // A finished sample waits while the previous result is not taken.
    a_finish_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH && m_valid_reg && !m_ready |=> state_reg == ST_FINISH)
        else $error("finished sample overwrote a pending result");

    // Delay words are written only in the two write-back steps or the clearing pass.
    a_delay_write_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        dly_we |-> state_reg == ST_CLEAR || step_reg == STEP_W || step_reg == STEP_M2)
        else $error("delay memory written outside write-back steps");

endmodule

// ===== hw/rtl/ebc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ebc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 240
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== tb/tb_eq_biquad_cascade_unit.sv =====
// Self-checking testbench for the cascaded biquad equalizer, with its own fixed-point model.
module tb_eq_biquad_cascade_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ebc_pkg::*;

    localparam int CHANNELS         = 8;
    localparam int BANDS            = 6;
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 4;
    localparam int RANDOM_PER_PHASE = 375;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int DRAIN_CYCLES     = 200;

    localparam logic signed [71:0] HALF_LSB = 72'sd1 <<< (QSHIFT - 1);
    // Stable feedback range (about +/-0.45) and feedforward range (+/-2.0).
    localparam int FB_SPAN = 120795955;
    localparam int FF_SPAN = 536870912;

    typedef struct packed {
        logic [0:0]  mode;
        logic [2:0]  channel;
        logic [2:0]  band;
        logic [2:0]  coef_index;
        logic [31:0] coef_value;
        logic [23:0] sample;
    } eq_item_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic [23:0] sample;
        logic        clipped;
    } eq_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [0:0]  s_mode = MODE_SAMPLE;
    logic [2:0]  s_channel = '0;
    logic [2:0]  s_band = '0;
    logic [2:0]  s_coef_index = '0;
    logic [31:0] s_coef_value = '0;
    logic [23:0] s_sample = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_out_channel;
    logic [23:0] m_out_sample;
    logic        m_clipped;

    eq_item_t   eq_requests[$];
    eq_result_t expected_outputs[$];
    eq_item_t   item_on_bus;

    logic signed [31:0] delay_words [CHANNELS][BANDS][2];
    logic signed [31:0] coef_words  [CHANNELS][BANDS][NUM_COEFS];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int fail_count      = 0;
    int cycle_count     = 0;

    eq_biquad_cascade_unit #(
        .CHANNELS (CHANNELS),
        .BANDS    (BANDS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_channel     (s_channel),
        .s_band        (s_band),
        .s_coef_index  (s_coef_index),
        .s_coef_value  (s_coef_value),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_out_sample  (m_out_sample),
        .m_clipped     (m_clipped)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Exact sum of three Q3.28 products, rounded to nearest with ties upward.
    function automatic logic signed [71:0] q28_mac(
        input logic signed [31:0] a0, b0, a1, b1, a2, b2
    );
        logic signed [71:0] acc;
        acc = a0 * b0 + a1 * b1 + a2 * b2 + HALF_LSB;
        return acc >>> QSHIFT;
    endfunction

    function automatic eq_result_t filter_sample(
        input logic [2:0] ch,
        input logic signed [23:0] x_in
    );
        logic signed [71:0] acc;
        logic signed [31:0] w;
        logic signed [31:0] d0;
        logic signed [31:0] d1;
        logic signed [23:0] x;
        logic clip;
        eq_result_t res;
        x = x_in;
        clip = 1'b0;
        for (int b = 0; b < BANDS; b++) begin
            d0 = delay_words[ch][b][0];
            d1 = delay_words[ch][b][1];
            acc = x + q28_mac(coef_words[ch][b][COEF_C0], d0,
                              coef_words[ch][b][COEF_C1], d1, 32'sd0, 32'sd0);
            if (acc > $signed(W_MAX)) begin
                w = W_MAX;
                clip = 1'b1;
            end else if (acc < $signed(W_MIN)) begin
                w = W_MIN;
                clip = 1'b1;
            end else begin
                w = acc[31:0];
            end
            acc = q28_mac(coef_words[ch][b][COEF_C2], w,
                          coef_words[ch][b][COEF_C3], d0,
                          coef_words[ch][b][COEF_C4], d1);
            if (acc > $signed(Y_MAX)) begin
                x = Y_MAX;
                clip = 1'b1;
            end else if (acc < $signed(Y_MIN)) begin
                x = Y_MIN;
                clip = 1'b1;
            end else begin
                x = acc[23:0];
            end
            delay_words[ch][b][1] = d0;
            delay_words[ch][b][0] = w;
        end
        res.channel = ch;
        res.sample  = x;
        res.clipped = clip;
        return res;
    endfunction

    task automatic apply_eq_item(input eq_item_t it);
        if (it.channel < CHANNELS) begin
            if (it.mode == MODE_COEF) begin
                if (it.band < BANDS && it.coef_index < NUM_COEFS)
                    coef_words[it.channel][it.band][it.coef_index] = it.coef_value;
            end else begin
                expected_outputs.push_back(filter_sample(it.channel, it.sample));
            end
        end
    endtask

    task automatic push_sample(input logic [2:0] ch, input logic [23:0] x);
        eq_item_t it;
        it.mode       = MODE_SAMPLE;
        it.channel    = ch;
        it.band       = 3'($urandom);
        it.coef_index = 3'($urandom);
        it.coef_value = $urandom;
        it.sample     = x;
        eq_requests.push_back(it);
    endtask

    task automatic push_coef(input logic [2:0] ch, input logic [2:0] band,
                             input logic [2:0] idx, input logic [31:0] value);
        eq_item_t it;
        it.mode       = MODE_COEF;
        it.channel    = ch;
        it.band       = band;
        it.coef_index = idx;
        it.coef_value = value;
        it.sample     = 24'($urandom);
        eq_requests.push_back(it);
    endtask

    function automatic eq_item_t random_item();
        eq_item_t it;
        int unsigned r;
        it.mode       = ($urandom_range(99) < 35) ? MODE_COEF : MODE_SAMPLE;
        it.channel    = 3'($urandom_range(7));
        it.band       = 3'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                    : $urandom_range(BANDS - 1));
        it.coef_index = 3'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                    : $urandom_range(NUM_COEFS - 1));
        r = $urandom_range(99);
        if (it.mode == MODE_SAMPLE || r < 15)
            it.coef_value = $urandom;
        else if (it.coef_index == COEF_C0 || it.coef_index == COEF_C1)
            it.coef_value = int'($urandom_range(2 * FB_SPAN)) - FB_SPAN;
        else
            it.coef_value = int'($urandom_range(2 * FF_SPAN)) - FF_SPAN;
        r = $urandom_range(99);
        if (r < 5)
            it.sample = Y_MAX;
        else if (r < 10)
            it.sample = Y_MIN;
        else if (r < 20)
            it.sample = 24'(int'($urandom_range(2000)) - 1000);
        else
            it.sample = 24'($urandom);
        return it;
    endfunction

    // Sender: holds each item until its transfer, then may idle before the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                apply_eq_item(item_on_bus);
            if (!s_valid || s_ready) begin
                if (eq_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    item_on_bus = eq_requests.pop_front();
                    s_valid      <= 1'b1;
                    s_mode       <= item_on_bus.mode;
                    s_channel    <= item_on_bus.channel;
                    s_band       <= item_on_bus.band;
                    s_coef_index <= item_on_bus.coef_index;
                    s_coef_value <= item_on_bus.coef_value;
                    s_sample     <= item_on_bus.sample;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer against the oldest expected output.
    always @(posedge aclk) begin
        eq_result_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual ch %0d sample %h clip %b",
                             $time, m_out_channel, m_out_sample, m_clipped);
                end else begin
                    exp_res = expected_outputs.pop_front();
                    if (m_out_channel !== exp_res.channel || m_out_sample !== exp_res.sample ||
                        m_clipped !== exp_res.clipped) begin
                        fail_count++;
                        if (m_out_channel !== exp_res.channel)
                            $display("%0t: out_channel mismatch: expected %0d, actual %0d",
                                     $time, exp_res.channel, m_out_channel);
                        if (m_out_sample !== exp_res.sample)
                            $display("%0t: out_sample mismatch: expected %h, actual %h",
                                     $time, exp_res.sample, m_out_sample);
                        if (m_clipped !== exp_res.clipped)
                            $display("%0t: clipped mismatch: expected %b, actual %b",
                                     $time, exp_res.clipped, m_clipped);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Lets the queued items drain, then waits until every result is back.
    // Checks are made at the falling edge, after the rising-edge updates have settled.
    task automatic drain_all();
        while (eq_requests.size() != 0 || s_valid)
            @(negedge aclk);
        while (expected_outputs.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            eq_requests.push_back(random_item());
        drain_all();
    endtask

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            for (int b = 0; b < BANDS; b++) begin
                delay_words[c][b][0] = '0;
                delay_words[c][b][1] = '0;
                for (int k = 0; k < NUM_COEFS; k++)
                    coef_words[c][b][k] = (k == COEF_C2) ? Q_ONE : '0;
            end
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Passthrough at the sample extremes; unused fields carry random values.
        push_sample(3'd0, Y_MAX);
        push_sample(3'd0, Y_MIN);
        push_sample(3'd7, 24'd0);
        // Writes to a band or slot out of range must leave channel 1 untouched.
        push_coef(3'd1, 3'd6, COEF_C2, 32'd0);
        push_coef(3'd1, 3'd7, COEF_C0, W_MAX);
        push_coef(3'd1, 3'd0, 3'd5, 32'd0);
        push_coef(3'd1, 3'd0, 3'd7, W_MIN);
        push_sample(3'd1, Y_MAX);
        // Largest gain clips the output in both directions.
        push_coef(3'd2, 3'd0, COEF_C2, W_MAX);
        push_sample(3'd2, Y_MAX);
        push_sample(3'd2, Y_MIN);
        // Runaway feedback drives the state word into saturation.
        push_coef(3'd3, 3'd0, COEF_C0, W_MAX);
        push_coef(3'd3, 3'd5, COEF_C3, W_MIN);
        push_coef(3'd3, 3'd5, COEF_C4, Q_ONE >> 1);
        push_coef(3'd3, 3'd2, COEF_C1, -(Q_ONE >> 1));
        repeat (5) push_sample(3'd3, Y_MAX);
        // A gain of one half puts odd samples exactly on a rounding tie.
        push_coef(3'd4, 3'd0, COEF_C2, Q_ONE >> 1);
        push_sample(3'd4, 24'd1);
        push_sample(3'd4, -24'sd1);
        push_sample(3'd4, 24'd3);
        push_sample(3'd4, -24'sd3);

        run_phase(0, 0);
        run_phase(48, 0);
        run_phase(0, 48);
        run_phase(6, 6);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_outputs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
